// ===== design/mcal_pkg.sv =====
package mcal_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int AXIS_MAX = 3;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSETS_ENABLED       = 2'd0,
    CFG_READ_INTERVAL_US      = 2'd1,
    CFG_CALIBRATION_WINDOW_US = 2'd2
  } mcal_cfg_idx_t;

  localparam logic [TIME_W-1:0] READ_INTERVAL_RST = 32'd100000;
  localparam logic [TIME_W-1:0] CAL_WINDOW_RST    = 32'd30000000;

  // Per-axis control for one processed sample; all terms but enable are already
  // qualified by the sample being taken.
  typedef struct packed {
    logic seed;
    logic enable;
    logic widen;
    logic save;
  } mcal_ctrl_t;

endpackage

// ===== design/mcal_axis.sv =====
module mcal_axis #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcal_pkg::mcal_ctrl_t            ctrl,
  input  logic [mcal_pkg::SAMPLE_W-1:0]   raw,
  output logic [mcal_pkg::SAMPLE_W-1:0]   corrected
);
  import mcal_pkg::*;

  logic signed [SAMPLE_BITS-1:0] min_r, max_r, off_r;
  logic signed [SAMPLE_BITS-1:0] min_nxt, max_nxt, off_nxt;
  logic signed [SAMPLE_BITS-1:0] s, base_off, corr, mn, mx, half;
  logic signed [SAMPLE_BITS:0]   sum, sum_adj;

  assign s        = signed'(raw[SAMPLE_BITS-1:0]);
  // A new calibration clears the offset before the sample is corrected.
  assign base_off = ctrl.seed ? '0 : off_r;
  assign corr     = ctrl.enable ? SAMPLE_BITS'(s - base_off) : s;
  assign mn       = ctrl.seed ? s : min_r;
  assign mx       = ctrl.seed ? s : max_r;

  assign min_nxt = (ctrl.widen && (corr < mn)) ? corr : mn;
  assign max_nxt = (ctrl.widen && (corr > mx)) ? corr : mx;

  // Midpoint truncated toward zero: add one to a negative sum before halving.
  assign sum     = {mn[SAMPLE_BITS-1], mn} + {mx[SAMPLE_BITS-1], mx};
  assign sum_adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]};
  assign half    = sum_adj[SAMPLE_BITS:1];

  assign off_nxt = ctrl.save ? half : base_off;

  assign corrected = SAMPLE_W'(corr);

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else begin
      off_r <= off_nxt;
    end
  end

endmodule

// ===== design/magnetometer_offset_calibrator.sv =====
// Hard-iron offset calibrator for a three-axis magnetometer stream. Every input
// transfer yields exactly one result transfer; a sample that arrives before the
// stored deadline comes back with the accepted flag low and zero data. The block
// takes one sample per clock cycle unless the result side stalls, a rate set by
// the deadline and window update, which is computed combinationally from its own
// registers. Each result passes through the input register, then the result
// register; it is delayed further only while the result side stalls.
// Offsets are the midpoint of the per-axis minimum and maximum collected over
// the calibration window and are subtracted only when offsets_enabled is set.
module magnetometer_offset_calibrator #(
  parameter int AXIS_COUNT  = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // time_us [31:0], raw_x [47:32], raw_y [63:48], raw_z [79:64]
  input  logic [79:0]                     in_tdata,
  // start_calibration [0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // corrected_x [15:0], corrected_y [31:16], corrected_z [47:32]
  output logic [47:0]                     out_tdata,
  // accepted [0], calibrating [1], offsets_saved [2]
  output logic [2:0]                      out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [mcal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcal_pkg::CFG_W-1:0]      cfg_wdata
);
  import mcal_pkg::*;

  logic              en_r;
  logic [TIME_W-1:0] interval_r, window_r;

  logic              in_valid_r;
  logic [79:0]       in_data_r;
  logic              in_start_r;

  logic [TIME_W-1:0] next_read_r, next_read_nxt;
  logic [TIME_W-1:0] win_start_r, win_start_nxt;
  logic              active_r, active_nxt;

  logic              out_valid_r;
  logic [47:0]       out_data_r;
  logic [2:0]        out_user_r;

  logic              adv, proc, acc, active_pre, in_window;
  logic [TIME_W-1:0] now, diff;
  mcal_ctrl_t        ctrl;
  logic [SAMPLE_W-1:0] corr_w [AXIS_MAX];
  logic [47:0]       data_nxt;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b0;
      interval_r <= READ_INTERVAL_RST;
      window_r   <= CAL_WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OFFSETS_ENABLED:       en_r       <= cfg_wdata[0];
        CFG_READ_INTERVAL_US:      interval_r <= cfg_wdata;
        CFG_CALIBRATION_WINDOW_US: window_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free
  // or is being emptied in this cycle.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;
  assign proc      = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  // Deadline and window control
  assign now  = in_data_r[TIME_W-1:0];
  assign diff = now - next_read_r;
  assign acc  = !diff[TIME_W-1];

  assign next_read_nxt = (proc && acc) ? now + interval_r : next_read_r;
  assign win_start_nxt = (proc && acc && in_start_r) ? next_read_nxt : win_start_r;
  assign active_pre    = in_start_r || active_r;
  assign in_window     = (next_read_nxt - win_start_nxt) < window_r;
  assign active_nxt    = (proc && acc) ? (active_pre && in_window) : active_r;

  assign ctrl.seed   = proc && acc && in_start_r;
  assign ctrl.enable = en_r;
  assign ctrl.widen  = proc && acc && active_pre && in_window;
  assign ctrl.save   = proc && acc && active_pre && !in_window;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_read_r <= '0;
      win_start_r <= '0;
      active_r    <= 1'b0;
    end else begin
      next_read_r <= next_read_nxt;
      win_start_r <= win_start_nxt;
      active_r    <= active_nxt;
    end
  end

  for (genvar a = 0; a < AXIS_MAX; a++) begin : g_axis
    if (a < AXIS_COUNT) begin : g_lane
      mcal_axis #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .raw       (in_data_r[TIME_W + a*SAMPLE_W +: SAMPLE_W]),
        .corrected (corr_w[a])
      );
    end else begin : g_unused
      assign corr_w[a] = '0;
    end
  end

  assign data_nxt = acc ? {corr_w[2], corr_w[1], corr_w[0]} : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= data_nxt;
      out_user_r <= {ctrl.save, active_nxt, acc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Saving offsets always closes the window on a sample that was taken.
  a_save_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0] && !out_tuser[1])
    else $error("offsets saved on a result that is not a closing sample");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("early sample carries non-zero data");

  a_deadline_hold: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !acc |=> $stable(next_read_r) && $stable(active_r))
    else $error("early sample changed the calibration state");

  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule
